/* src/wavelet_mask_fir_filter_top_assert.svh */
// Assertion macros shared by the filter modules.
// Each macro expects clk and arst_n in scope.
`ifndef WAVELET_MASK_FIR_FILTER_TOP_ASSERT_SVH
`define WAVELET_MASK_FIR_FILTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define WMF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wmf assertion failed");

// Next-cycle implication.
`define WMF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wmf assertion failed");

`endif

/* src/wmf_pkg.sv */
// ----------------------------------------------------------------------------
// wmf_pkg
// Types, widths and register codes shared by the mask filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wmf_pkg;

	localparam int SAMPLE_BITS    = 32;
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_BITS      = 18;
	localparam int NUM_TAPS       = 5;
	// five products of SAMPLE_BITS x COEF_BITS plus growth of the sum
	localparam int SUM_BITS       = SAMPLE_BITS + COEF_BITS + 3;
	localparam int COUNT_BITS     = 3;
	localparam int RES_BITS       = 2;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = COEF_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(NUM_TAPS);

	localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_MODE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_0      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_1      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_2      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_3      = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_4      = 3'd5;

	localparam logic MODE_LINEAR  = 1'b0;
	localparam logic MODE_BICUBIC = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef sample_t window_t [NUM_TAPS];
	typedef coef_t   coef_bank_t [NUM_TAPS];

	typedef struct packed {
		sample_t sample_value;
		logic    is_last;
	} in_item_t;

	typedef struct packed {
		sample_t filtered_value;
		logic    last_out;
	} out_item_t;

	// per-item control carried alongside the captured window
	typedef struct packed {
		logic                mode;
		logic                use_filter;
		logic [RES_BITS-1:0] num_results;
		logic                is_last;
	} item_ctrl_t;

endpackage

`default_nettype wire

/* src/wmf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// wmf_cfg_regs
// Kernel mode and mask coefficient registers behind the write port.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_cfg_regs
	import wmf_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
	output logic                          kernel_mode,
	output coef_bank_t                    coefs
);

	logic       kernel_mode_q;
	coef_bank_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_mode_q <= MODE_LINEAR;
			for (int k = 0; k < NUM_TAPS; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KERNEL_MODE: kernel_mode_q <= cfg_wdata[0];
				REG_COEF_0:      coef_q[0] <= coef_t'(cfg_wdata);
				REG_COEF_1:      coef_q[1] <= coef_t'(cfg_wdata);
				REG_COEF_2:      coef_q[2] <= coef_t'(cfg_wdata);
				REG_COEF_3:      coef_q[3] <= coef_t'(cfg_wdata);
				REG_COEF_4:      coef_q[4] <= coef_t'(cfg_wdata);
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	assign kernel_mode = kernel_mode_q;
	assign coefs       = coef_q;

endmodule

`default_nettype wire

/* src/wmf_window.sv */
// ----------------------------------------------------------------------------
// wmf_window
// Sample window and count; captures each item into the stage-one register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wavelet_mask_fir_filter_top_assert.svh"

module wmf_window
	import wmf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        kernel_mode,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	input  wire logic        s1_take,
	output logic             s1_valid,
	output window_t          window_s1,
	output item_ctrl_t       ctrl_s1
);

	window_t                win_q;
	window_t                win_next;
	logic [COUNT_BITS-1:0]  count_q;
	logic                   s1_valid_q;
	window_t                win_s1;
	item_ctrl_t             ctl_s1;
	item_ctrl_t             ctl_next;
	logic                   in_fire;

	assign in_ready = !s1_valid_q || s1_take;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		logic [COUNT_BITS-1:0] clip;
		logic                  full;
		clip = (kernel_mode == MODE_BICUBIC) ? COUNT_BITS'(2) : COUNT_BITS'(1);
		full = (count_q >= clip);

		win_next[0] = in_data.sample_value;
		for (int k = 1; k < NUM_TAPS; k++) begin
			win_next[k] = win_q[k-1];
		end

		ctl_next.mode       = kernel_mode;
		ctl_next.is_last    = in_data.is_last;
		ctl_next.use_filter = (count_q >= (clip << 1));
		if (in_data.is_last) begin
			// one result, then trailing zeros; a short signal gives zeros only
			ctl_next.num_results = full ? RES_BITS'(clip + COUNT_BITS'(1))
				: RES_BITS'(count_q + COUNT_BITS'(1));
		end else begin
			ctl_next.num_results = full ? RES_BITS'(1) : RES_BITS'(0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			s1_valid_q <= 1'b0;
			for (int k = 0; k < NUM_TAPS; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
				if (in_data.is_last) begin
					count_q <= '0;
					for (int k = 0; k < NUM_TAPS; k++) begin
						win_q[k] <= '0;
					end
				end else begin
					win_q <= win_next;
					if (count_q < COUNT_MAX) begin
						count_q <= count_q + COUNT_BITS'(1);
					end
				end
			end else if (s1_take) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			win_s1 <= win_next;
			ctl_s1 <= ctl_next;
		end
	end

	assign s1_valid  = s1_valid_q;
	assign window_s1 = win_s1;
	assign ctrl_s1   = ctl_s1;

	`WMF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= COUNT_MAX)
	`WMF_ASSERT_NEXT(a_last_clears, in_fire && in_data.is_last, count_q == '0)
	`WMF_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_take, s1_valid_q)

endmodule

`default_nettype wire

/* src/wmf_mac.sv */
// ----------------------------------------------------------------------------
// wmf_mac
// Multiply-accumulate over the window, round half up, saturate to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_mac
	import wmf_pkg::*;
(
	input  wire window_t    window_s1,
	input  wire logic       mode_s1,
	input  wire coef_bank_t coefs,
	output sample_t         filt_value
);

	localparam logic signed [SUM_BITS-1:0] HALF =
		$signed(SUM_BITS'(1) << (COEF_FRAC_BITS - 1));
	localparam logic signed [SUM_BITS-1:0] SAT_MAX =
		$signed({{(SUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [SUM_BITS-1:0] SAT_MIN = -SAT_MAX - SUM_BITS'(1);

	always_comb begin
		logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod;
		logic signed [SUM_BITS-1:0]              acc;
		logic signed [SUM_BITS-1:0]              rounded;
		sample_t                                 x;
		acc = '0;
		for (int m = 0; m < NUM_TAPS; m++) begin
			// window is newest first; tap m reads sample taps-1-m
			if (mode_s1 == MODE_BICUBIC) begin
				x = window_s1[NUM_TAPS-1-m];
			end else if (m < 3) begin
				x = window_s1[2-m];
			end else begin
				x = '0;
			end
			prod = x * coefs[m];
			acc  = acc + SUM_BITS'(prod);
		end
		rounded = (acc + HALF) >>> COEF_FRAC_BITS;
		if (rounded > SAT_MAX) begin
			filt_value = SAT_MAX[SAMPLE_BITS-1:0];
		end else if (rounded < SAT_MIN) begin
			filt_value = SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			filt_value = rounded[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

/* src/wmf_out_stage.sv */
// ----------------------------------------------------------------------------
// wmf_out_stage
// Result register; emits the filtered value, then any trailing zeros.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wavelet_mask_fir_filter_top_assert.svh"

module wmf_out_stage
	import wmf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s1_valid,
	input  wire item_ctrl_t ctrl_s1,
	input  wire sample_t    filt_value,
	output logic            s1_take,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_item_t       out_data
);

	logic [RES_BITS-1:0] rem_q;
	sample_t             value_q;
	logic                last_q;
	logic                drain;

	// free now, or the final result leaves this cycle
	assign drain   = (rem_q == '0) || ((rem_q == RES_BITS'(1)) && out_ready);
	assign s1_take = s1_valid && drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (s1_take) begin
			rem_q <= ctrl_s1.num_results;
		end else if (out_ready && (rem_q != '0)) begin
			rem_q <= rem_q - RES_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			value_q <= ctrl_s1.use_filter ? filt_value : '0;
			last_q  <= ctrl_s1.is_last;
		end else if (out_ready && (rem_q != '0)) begin
			// every result after the first is a zero
			value_q <= '0;
		end
	end

	assign out_valid               = (rem_q != '0);
	assign out_data.filtered_value = value_q;
	assign out_data.last_out       = last_q && (rem_q == RES_BITS'(1));

	`WMF_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, $stable(rem_q))
	`WMF_ASSERT_NOW(a_no_overwrite, s1_take && out_valid, (rem_q == RES_BITS'(1)) && out_ready)
	`WMF_ASSERT_NOW(a_zero_tail, out_valid && !out_data.last_out && !last_q, rem_q == RES_BITS'(1))

endmodule

`default_nettype wire

/* src/wavelet_mask_fir_filter_top.sv */
// ----------------------------------------------------------------------------
// wavelet_mask_fir_filter_top
// Streaming 3-tap / 5-tap correlation filter on signed Q16.16 samples.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  in        in_valid / in_ready     in_data (sample_value, is_last)
//  out       out_valid / out_ready   out_data (filtered_value, last_out)
//  cfg       cfg_wr_en               cfg_index, cfg_wdata
//
//  One input transaction per cycle while in_ready is high. A last sample yields up to
//  three results, one per cycle from the result register while out_ready is high, so
//  the input stalls behind it as they drain. The five multipliers and the adder tree
//  sit between the stage-one and result registers. Reset clears the window,
//  the count, the valid flags and the mask registers. Stalls on out hold the result
//  and back-pressure in after one buffered transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module wavelet_mask_fir_filter_top
	import wmf_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire in_item_t                 in_data,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output out_item_t                     out_data,
	input  wire logic                     cfg_wr_en,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	logic       kernel_mode;
	coef_bank_t coefs;
	logic       s1_valid;
	logic       s1_take;
	window_t    window_s1;
	item_ctrl_t ctrl_s1;
	sample_t    filt_value;

	wmf_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.kernel_mode (kernel_mode),
		.coefs       (coefs)
	);

	wmf_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.kernel_mode (kernel_mode),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.s1_take     (s1_take),
		.s1_valid    (s1_valid),
		.window_s1   (window_s1),
		.ctrl_s1     (ctrl_s1)
	);

	wmf_mac u_mac (
		.window_s1  (window_s1),
		.mode_s1    (ctrl_s1.mode),
		.coefs      (coefs),
		.filt_value (filt_value)
	);

	wmf_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.ctrl_s1    (ctrl_s1),
		.filt_value (filt_value),
		.s1_take    (s1_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3-tap / 5-tap mask filter. A scoreboard keeps
// its own copy of the sample window, the count and the registers, predicts
// the results of every accepted sample and compares them field by field with
// what leaves the block. Directed signals hit the edge cases, then random
// signals run under random register settings with random stalls on both sides.
// ----------------------------------------------------------------------------

module testbench;
	import wmf_pkg::*;

	localparam int          DRAIN_CYCLES  = 8;
	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          RANDOM_ITEMS  = 250;
	localparam int          PHASE_SIGNALS = 6;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_HI = 3'd7;

	localparam coef_t   COEF_HI   = 18'h1FFFF;
	localparam coef_t   COEF_LO   = 18'h20000;
	localparam coef_t   COEF_ONE  = 18'h10000;
	localparam sample_t SAMPLE_HI = 32'h7FFFFFFF;
	localparam sample_t SAMPLE_LO = 32'h80000000;

	typedef enum {FILL_RANDOM, FILL_HI, FILL_LO} fill_kind_t;

	class mask_filter_scoreboard;
		logic        mode;
		coef_t       coefs[NUM_TAPS];
		sample_t     window[NUM_TAPS];
		int unsigned count;
		out_item_t   expected_q[$];
		int          errors;

		function new();
			mode = MODE_LINEAR;
			count = 0;
			errors = 0;
			foreach (coefs[k]) coefs[k] = '0;
			foreach (window[k]) window[k] = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx) inside
				REG_KERNEL_MODE: mode = data[0];
				REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4:
					coefs[idx - REG_COEF_0] = coef_t'(data);
				default: ; // unmapped index: drop the write
			endcase
		endfunction

		// oldest sample of the active window meets the first coefficient
		function sample_t apply_mask(int unsigned taps);
			longint acc;
			longint rounded;
			longint sat_hi;
			acc = 0;
			sat_hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
			for (int m = 0; m < taps; m++)
				acc += longint'(window[taps - 1 - m]) * longint'(coefs[m]);
			rounded = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
			if (rounded > sat_hi)
				rounded = sat_hi;
			if (rounded < -sat_hi - 1)
				rounded = -sat_hi - 1;
			return sample_t'(rounded);
		endfunction

		function void queue_result(sample_t value, logic last);
			out_item_t r;
			r.filtered_value = value;
			r.last_out = last;
			expected_q.push_back(r);
		endfunction

		function void note_sample(in_item_t item);
			int unsigned clip;
			int unsigned taps;
			int unsigned idx;
			sample_t     y;
			clip = (mode == MODE_BICUBIC) ? 2 : 1;
			taps = 2 * clip + 1;
			idx = count;
			for (int k = NUM_TAPS - 1; k > 0; k--)
				window[k] = window[k - 1];
			window[0] = item.sample_value;
			if (count < NUM_TAPS)
				count++;
			y = (idx >= 2 * clip) ? apply_mask(taps) : '0;
			if (item.is_last) begin
				if (idx >= clip) begin
					queue_result(y, 1'b0);
					for (int k = 0; k < clip; k++)
						queue_result('0, k + 1 == clip);
				end else begin
					for (int k = 0; k <= idx; k++)
						queue_result('0, k == idx);
				end
				foreach (window[k]) window[k] = '0;
				count = 0;
			end else if (idx >= clip) begin
				queue_result(y, 1'b0);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result value=%0d last=%0b",
					$time, got.filtered_value, got.last_out);
				return;
			end
			want = expected_q.pop_front();
			if (got.filtered_value !== want.filtered_value) begin
				errors++;
				$display("%0t: filtered_value expected %0d got %0d",
					$time, want.filtered_value, got.filtered_value);
			end
			if (got.last_out !== want.last_out) begin
				errors++;
				$display("%0t: last_out expected %0b got %0b",
					$time, want.last_out, got.last_out);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	in_item_t                 in_data;
	logic                     out_valid;
	logic                     out_ready;
	out_item_t                out_data;
	logic                     cfg_wr_en;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	mask_filter_scoreboard filter_sb;
	int  cycle_count;
	int  items_sent;
	int  sink_stall;
	bit  src_quiet;
	bit  sink_quiet;

	wavelet_mask_fir_filter_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// observe both channels at the rising edge; inputs first so that
	// predictions are queued before any result of the same edge is checked
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n) begin
			if (in_valid && in_ready)
				filter_sb.note_sample(in_data);
			if (out_valid && out_ready) begin
				filter_sb.check_result(out_data);
				sink_stall = sink_quiet ? 0 : $urandom_range(0, 3);
			end
		end
	end

	// hold ready low for the drawn stall, then raise it until the next transaction
	always @(negedge clk) begin
		if (sink_stall != 0) begin
			out_ready <= 1'b0;
			sink_stall = sink_stall - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic coef_t pick_coef();
		case ($urandom_range(0, 5))
			0: return COEF_HI;
			1: return COEF_LO;
			2: return '0;
			3: return COEF_ONE;
			default: return coef_t'($urandom);
		endcase
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_HI;
			1: return SAMPLE_LO;
			2: return sample_t'(int'($urandom_range(0, 262143)) - 131072);
			3: return '0;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_sample(input sample_t value, input logic last);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= '{sample_value: value, is_last: last};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_signal(input int unsigned len, input fill_kind_t fill);
		sample_t value;
		for (int unsigned k = 0; k < len; k++) begin
			case (fill)
				FILL_HI: value = SAMPLE_HI;
				FILL_LO: value = SAMPLE_LO;
				default: value = pick_sample();
			endcase
			send_sample(value, k + 1 == len);
		end
	endtask

	// drop valid, let every expected result drain, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (filter_sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		filter_sb.write_reg(idx, data);
	endtask

	task automatic cfg_close();
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mode goes in bit zero; the other bits carry noise
	task automatic write_mode(input logic mode);
		logic [CFG_DATA_BITS-1:0] data;
		data = CFG_DATA_BITS'($urandom);
		data[0] = mode;
		cfg_write(REG_KERNEL_MODE, data);
	endtask

	task automatic configure(input logic mode, input coef_t c0, input coef_t c1,
		input coef_t c2, input coef_t c3, input coef_t c4);
		write_mode(mode);
		cfg_write(REG_COEF_0, c0);
		cfg_write(REG_COEF_1, c1);
		cfg_write(REG_COEF_2, c2);
		cfg_write(REG_COEF_3, c3);
		cfg_write(REG_COEF_4, c4);
		if ($urandom_range(0, 2) == 0)
			cfg_write($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
				CFG_DATA_BITS'($urandom));
		cfg_close();
	endtask

	initial begin
		int unsigned len;
		int          phase_signals;
		filter_sb = new();
		cycle_count = 0;
		items_sent = 0;
		sink_stall = 0;
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// linear mask at full positive gain: short signals, then saturation
		configure(MODE_LINEAR, COEF_HI, COEF_HI, COEF_HI, COEF_LO, COEF_LO);
		cfg_write(REG_UNUSED_LO, CFG_DATA_BITS'($urandom));
		cfg_write(REG_UNUSED_HI, CFG_DATA_BITS'($urandom));
		cfg_close();
		send_signal(1, FILL_HI);
		send_signal(2, FILL_LO);
		send_signal(3, FILL_HI);
		wait_idle();

		// bicubic mask at full negative gain: too short, exact fit
		configure(MODE_BICUBIC, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO);
		send_signal(1, FILL_LO);
		send_signal(4, FILL_HI);
		send_signal(5, FILL_HI);
		wait_idle();

		// switch the mask in the middle of a signal
		configure(MODE_LINEAR, COEF_ONE, pick_coef(), pick_coef(), pick_coef(), pick_coef());
		for (int k = 0; k < 3; k++)
			send_sample(pick_sample(), 1'b0);
		wait_idle();
		write_mode(MODE_BICUBIC);
		cfg_close();
		for (int k = 0; k < 3; k++)
			send_sample(pick_sample(), k == 2);
		wait_idle();

		phase_signals = PHASE_SIGNALS;
		while (items_sent < RANDOM_ITEMS) begin
			if (phase_signals == PHASE_SIGNALS) begin
				wait_idle();
				configure(1'($urandom_range(0, 1)), pick_coef(), pick_coef(), pick_coef(),
					pick_coef(), pick_coef());
				phase_signals = 0;
			end
			src_quiet = ($urandom_range(0, 3) == 0);
			sink_quiet = ($urandom_range(0, 3) == 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 7);
			send_signal(len, FILL_RANDOM);
			phase_signals++;
		end

		wait_idle();
		if (filter_sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
